[rtl/awrs_pkg.sv]
// Package for the alarm wake-up report scheduler.
// Holds the state, item and configuration types, register indexes and alarm codes.
// No dependencies.
package awrs_pkg;

  localparam logic [7:0]  ALARM_HIGH = 8'hF0;
  localparam logic [7:0]  ALARM_BATT = 8'h08;

  localparam logic [15:0] LONG_SLEEP_RST  = 16'd44531;
  localparam logic [15:0] SHORT_SLEEP_RST = 16'd5;
  localparam logic [7:0]  HB_WAKEUPS_RST  = 8'd8;
  localparam logic [7:0]  BATT_EVERY_RST  = 8'd4;

  typedef enum logic [1:0] {
    CFG_LONG_SLEEP  = 2'd0,
    CFG_SHORT_SLEEP = 2'd1,
    CFG_HB_WAKEUPS  = 2'd2,
    CFG_BATT_EVERY  = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [15:0] long_sleep_ticks;
    logic [15:0] short_sleep_ticks;
    logic [7:0]  heartbeat_wakeups;
    logic [7:0]  battery_every;
  } cfg_t;

  typedef struct packed {
    logic woke_by_pin;
    logic key_level;
    logic battery_low;
  } item_t;

  typedef struct packed {
    logic       event_mode;
    logic       event_phase;
    logic       heartbeat_phase;
    logic [7:0] wakeup_count;
    logic [7:0] heartbeat_count;
    logic       last_level;
    logic       battery_flag;
  } state_t;

  typedef struct packed {
    logic        send_report;
    logic [7:0]  alarm_byte;
    logic [15:0] next_sleep;
  } result_t;

  function automatic logic [7:0] make_alarm(input logic level, input logic batt);
    make_alarm = (level ? ALARM_HIGH : 8'h00) | (batt ? ALARM_BATT : 8'h00);
  endfunction

endpackage

[rtl/awrs_decide.sv]
// Per-wake-up decision logic: next state and result from current state and one item.
// Depends on awrs_pkg.
module awrs_decide import awrs_pkg::*; (
  input  cfg_t    cfg,
  input  state_t  st,
  input  item_t   item,
  output state_t  st_nxt,
  output result_t res
);

  logic [7:0] hb_inc;

  always_comb begin
    st_nxt = st;
    res    = '0;
    hb_inc = st.heartbeat_count + 8'd1;

    if (item.woke_by_pin) begin
      st_nxt.wakeup_count = '0;
      st_nxt.event_mode   = 1'b1;
      st_nxt.event_phase  = 1'b0;
    end
    // level change: immediate report, never with the battery bit
    if (item.key_level != st.last_level) begin
      st_nxt.wakeup_count = '0;
      st_nxt.event_phase  = 1'b0;
      st_nxt.event_mode   = 1'b1;
      st_nxt.last_level   = item.key_level;
      res.send_report     = 1'b1;
      res.alarm_byte      = make_alarm(item.key_level, 1'b0);
    end

    if (!st_nxt.event_mode) begin
      res.next_sleep = cfg.long_sleep_ticks;
      if (st_nxt.wakeup_count < cfg.heartbeat_wakeups) begin
        st_nxt.wakeup_count = st_nxt.wakeup_count + 8'd1;
      end else if (!st.heartbeat_phase) begin
        st_nxt.heartbeat_phase = 1'b1;
        if (hb_inc >= cfg.battery_every) begin
          st_nxt.heartbeat_count = '0;
          st_nxt.battery_flag    = item.battery_low;
        end else begin
          st_nxt.heartbeat_count = hb_inc;
          st_nxt.battery_flag    = 1'b0;
        end
        res.send_report = 1'b1;
        res.alarm_byte  = make_alarm(item.key_level, st_nxt.battery_flag);
        res.next_sleep  = cfg.short_sleep_ticks;
      end else begin
        st_nxt.heartbeat_phase = 1'b0;
        st_nxt.wakeup_count    = '0;
        res.send_report        = 1'b1;
        res.alarm_byte         = make_alarm(item.key_level, st.battery_flag);
      end
    end else if (!st_nxt.event_phase) begin
      st_nxt.event_phase = 1'b1;
      res.next_sleep     = cfg.short_sleep_ticks;
    end else begin
      st_nxt.event_phase = 1'b0;
      st_nxt.event_mode  = 1'b0;
      res.send_report    = 1'b1;
      res.alarm_byte     = make_alarm(item.key_level, 1'b0);
      res.next_sleep     = cfg.long_sleep_ticks;
    end
  end

endmodule

[rtl/alarm_wakeup_report_scheduler.sv]
// Top level of the alarm wake-up report scheduler: input register, decision, result register.
// Depends on awrs_pkg and awrs_decide.
//
//   channel | direction | payload                                 | handshake
//   in_     | in        | woke_by_pin, key_level, battery_low     | in_valid / in_ready
//   out_    | out       | send_report, alarm_byte, next_sleep     | out_valid / out_ready
//   cfg_    | in        | cfg_index (2b), cfg_data (16b)          | cfg_valid / cfg_ready
//
// One item per cycle sustained while the result is not stalled; each accepted item passes through
// the input register and then the result register.
// The scheduler state advances when an item moves from the input register into the result
// register. A stalled result holds both stages; the input register frees as soon as the
// result register can move. Synchronous reset clears state and loads register defaults.
module alarm_wakeup_report_scheduler import awrs_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_woke_by_pin,
  input  logic        in_key_level,
  input  logic        in_battery_low,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_send_report,
  output logic [7:0]  out_alarm_byte,
  output logic [15:0] out_next_sleep,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  cfg_t    cfg_r;
  state_t  st_r;
  state_t  st_nxt;
  item_t   s1_item_r;
  logic    s1_valid_r;
  logic    out_valid_r;
  result_t res_nxt;
  result_t res_r;
  logic    s2_take;

  assign s2_take   = !out_valid_r || out_ready;
  assign in_ready  = !s1_valid_r || s2_take;
  assign cfg_ready = 1'b1;

  awrs_decide u_decide (
    .cfg    (cfg_r),
    .st     (st_r),
    .item   (s1_item_r),
    .st_nxt (st_nxt),
    .res    (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r                  <= 1'b0;
      out_valid_r                 <= 1'b0;
      st_r                        <= '0;
      cfg_r.long_sleep_ticks      <= LONG_SLEEP_RST;
      cfg_r.short_sleep_ticks     <= SHORT_SLEEP_RST;
      cfg_r.heartbeat_wakeups     <= HB_WAKEUPS_RST;
      cfg_r.battery_every         <= BATT_EVERY_RST;
    end else begin
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      if (s2_take) begin
        out_valid_r <= s1_valid_r;
      end
      if (s1_valid_r && s2_take) begin
        st_r <= st_nxt;
      end
      if (cfg_valid) begin
        unique case (cfg_idx_t'(cfg_index))
          CFG_LONG_SLEEP:  cfg_r.long_sleep_ticks  <= cfg_data;
          CFG_SHORT_SLEEP: cfg_r.short_sleep_ticks <= cfg_data;
          CFG_HB_WAKEUPS:  cfg_r.heartbeat_wakeups <= cfg_data[7:0];
          CFG_BATT_EVERY:  cfg_r.battery_every     <= cfg_data[7:0];
          default: ;
        endcase
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_item_r.woke_by_pin <= in_woke_by_pin;
      s1_item_r.key_level   <= in_key_level;
      s1_item_r.battery_low <= in_battery_low;
    end
    if (s1_valid_r && s2_take) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_send_report = res_r.send_report;
  assign out_alarm_byte  = res_r.alarm_byte;
  assign out_next_sleep  = res_r.next_sleep;

endmodule

[rtl/awrs_checker.sv]
// Port-level assertions for the alarm wake-up report scheduler, bound to the top level.
// Depends on alarm_wakeup_report_scheduler.
module awrs_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_send_report,
  input logic [7:0]  out_alarm_byte,
  input logic [15:0] out_next_sleep
);

  // a stalled result item holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_alarm_byte)
      && $stable(out_send_report) && $stable(out_next_sleep))
    else $error("result item changed while stalled");

  a_quiet_no_report: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_send_report |-> out_alarm_byte == 8'h00)
    else $error("alarm byte set without a report");

  a_alarm_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_alarm_byte[2:0] == 3'b000
      && (out_alarm_byte[7:4] == 4'h0 || out_alarm_byte[7:4] == 4'hF))
    else $error("alarm byte outside the defined codes");

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid straight after reset");

endmodule

bind alarm_wakeup_report_scheduler awrs_checker u_awrs_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_send_report (out_send_report),
  .out_alarm_byte  (out_alarm_byte),
  .out_next_sleep  (out_next_sleep)
);
